// ===== hw/rtl/array_linked_list_engine_defines.svh =====
// Assertion macros for the linked list engine.
`ifndef ARRAY_LINKED_LIST_ENGINE_DEFINES_SVH
`define ARRAY_LINKED_LIST_ENGINE_DEFINES_SVH

`ifndef SYNTH
`define ALLE_ASSERT_SAME(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("linked list engine check failed");
`define ALLE_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("linked list engine check failed");
`else
`define ALLE_ASSERT_SAME(lbl, clk, rst_n, ante, cons)
`define ALLE_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif

`endif

// ===== hw/rtl/alle_pkg.sv =====
// Shared constants, types and word formats of the linked list engine.
package alle_pkg;

  localparam int SLOTS  = 16;
  localparam int SLOT_W = $clog2(SLOTS);
  localparam int CNT_W  = $clog2(SLOTS + 1);
  localparam int VAL_W  = 32;
  localparam int LEN_W  = 5;

  typedef logic [SLOT_W-1:0] slot_t;
  typedef logic [CNT_W-1:0]  cnt_t;

  typedef enum logic [1:0] {
    OP_APPEND    = 2'd0,
    OP_PUSH      = 2'd1,
    OP_DROP_TAIL = 2'd2,
    OP_DROP_HEAD = 2'd3
  } opcode_t;

  typedef enum logic [1:0] {
    ST_DONE  = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_WALK,
    S_LINK,
    S_RESP
  } state_t;

  typedef struct packed {
    opcode_t            opcode;
    logic signed [31:0] value;
  } in_word_t;

  typedef struct packed {
    status_t            status;
    logic [LEN_W-1:0]   length;
  } out_word_t;

  typedef struct packed {
    logic  en;
    slot_t addr;
    slot_t data;
  } link_wr_t;

  typedef struct packed {
    logic             en;
    slot_t            addr;
    logic [VAL_W-1:0] data;
  } val_wr_t;

endpackage

// ===== hw/rtl/alle_ram.sv =====
// Single-port-write, single-port-read synchronous RAM with registered read data.
module alle_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    rd_data <= mem[rd_addr];
  end

endmodule

// ===== hw/rtl/alle_ctrl.sv =====
// Command sequencer: slot allocation, head and count, link walks and store updates.
module alle_ctrl import alle_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_word_t  in_word,
  output link_wr_t  link_wr,
  output slot_t     link_rd_addr,
  input  slot_t     link_rd_data,
  output val_wr_t   val_wr,
  output logic      resp_valid,
  output out_word_t resp_word,
  input  logic      resp_ready
);

  state_t             state_r, state_nxt;
  slot_t              head_r, head_nxt;
  cnt_t               count_r, count_nxt;
  logic [SLOTS-1:0]   used_r, used_nxt;
  opcode_t            op_r, op_nxt;
  status_t            status_r, status_nxt;
  slot_t              q_r, q_nxt;
  slot_t              cur_r, cur_nxt;
  slot_t              tail_r, tail_nxt;
  slot_t              hops_r, hops_nxt;
  slot_t              free_slot;
  logic               cnt_full, cnt_zero, cnt_one;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      head_r  <= '0;
      count_r <= '0;
      used_r  <= '0;
    end else begin
      state_r <= state_nxt;
      head_r  <= head_nxt;
      count_r <= count_nxt;
      used_r  <= used_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r     <= op_nxt;
    status_r <= status_nxt;
    q_r      <= q_nxt;
    cur_r    <= cur_nxt;
    tail_r   <= tail_nxt;
    hops_r   <= hops_nxt;
  end

  always_comb begin
    free_slot = '0;
    for (int i = SLOTS - 1; i >= 0; i--) begin
      if (!used_r[i]) begin
        free_slot = SLOT_W'(i);
      end
    end
  end

  assign cnt_full = (count_r == CNT_W'(SLOTS));
  assign cnt_zero = (count_r == '0);
  assign cnt_one  = (count_r == CNT_W'(1));

  always_comb begin
    state_nxt    = state_r;
    head_nxt     = head_r;
    count_nxt    = count_r;
    used_nxt     = used_r;
    op_nxt       = op_r;
    status_nxt   = status_r;
    q_nxt        = q_r;
    cur_nxt      = cur_r;
    tail_nxt     = tail_r;
    hops_nxt     = hops_r;
    in_stall     = (state_r != S_IDLE);
    link_wr      = '0;
    val_wr       = '0;
    link_rd_addr = head_r;
    resp_valid   = 1'b0;
    resp_word    = '{status: status_r, length: LEN_W'(count_r)};

    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          op_nxt     = in_word.opcode;
          q_nxt      = free_slot;
          cur_nxt    = head_r;
          status_nxt = ST_DONE;
          state_nxt  = S_RESP;
          case (in_word.opcode)
            OP_APPEND, OP_PUSH: begin
              if (cnt_full) begin
                status_nxt = ST_FULL;
              end else begin
                val_wr = '{en: 1'b1, addr: free_slot, data: in_word.value};
                link_wr = '{en: 1'b1, addr: free_slot,
                            data: (in_word.opcode == OP_PUSH && !cnt_zero) ? head_r : '0};
                used_nxt[free_slot] = 1'b1;
                count_nxt = count_r + CNT_W'(1);
                if (in_word.opcode == OP_PUSH || cnt_zero) begin
                  head_nxt = free_slot;
                end else if (cnt_one) begin
                  tail_nxt  = head_r;
                  state_nxt = S_LINK;
                end else begin
                  hops_nxt  = SLOT_W'(count_r - CNT_W'(1));
                  state_nxt = S_WALK;
                end
              end
            end
            OP_DROP_TAIL, OP_DROP_HEAD: begin
              if (cnt_zero) begin
                status_nxt = ST_EMPTY;
              end else if (cnt_one) begin
                used_nxt[head_r] = 1'b0;
                head_nxt  = '0;
                count_nxt = '0;
              end else begin
                hops_nxt  = (in_word.opcode == OP_DROP_HEAD) ? SLOT_W'(1)
                                                             : SLOT_W'(count_r - CNT_W'(1));
                state_nxt = S_WALK;
              end
            end
            default: ;
          endcase
        end
      end
      S_WALK: begin
        if (hops_r == SLOT_W'(1)) begin
          state_nxt = S_RESP;
          case (op_r)
            OP_APPEND: begin
              tail_nxt  = link_rd_data;
              state_nxt = S_LINK;
            end
            OP_DROP_HEAD: begin
              head_nxt        = link_rd_data;
              used_nxt[cur_r] = 1'b0;
              count_nxt       = count_r - CNT_W'(1);
            end
            OP_DROP_TAIL: begin
              used_nxt[link_rd_data] = 1'b0;
              link_wr   = '{en: 1'b1, addr: cur_r, data: '0};
              count_nxt = count_r - CNT_W'(1);
            end
            default: ;
          endcase
        end else begin
          cur_nxt      = link_rd_data;
          hops_nxt     = hops_r - SLOT_W'(1);
          link_rd_addr = link_rd_data;
        end
      end
      S_LINK: begin
        link_wr   = '{en: 1'b1, addr: tail_r, data: q_r};
        state_nxt = S_RESP;
      end
      S_RESP: begin
        resp_valid = 1'b1;
        if (resp_ready) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

endmodule

// ===== hw/rtl/array_linked_list_engine.sv =====
// Top level of the array-backed singly linked list engine.
// Input channel: in_valid / in_stall / in_word carry one command word (opcode, value).
// Output channel: out_valid / out_stall / out_word carry one result word (status, length)
// for every command, in command order.
// One command is in flight at a time; in_stall is high from acceptance until the
// result word has been moved into the output register.
// Head insert, append to an empty list, removal from an empty or one-element list
// and refused commands go from acceptance straight to the response state. Head
// removal reads the link of the head once; tail append and tail removal walk the
// links through the registered-read link memory at one link per cycle, and an
// append then writes the link of the old tail. The next command is accepted from
// the cycle in which out_valid rises.
// While out_stall is high the result word holds in the output register; the
// next command is still accepted and runs up to its result, then waits.
// Reset (rst_n low, synchronous) empties the list and clears all slot used bits;
// the value and link memories are not cleared and need no sweep.
`include "array_linked_list_engine_defines.svh"

module array_linked_list_engine import alle_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_word_t  in_word,
  output logic      out_valid,
  input  logic      out_stall,
  output out_word_t out_word
);

  link_wr_t         link_wr;
  val_wr_t          val_wr;
  slot_t            link_rd_addr;
  slot_t            link_rd_data;
  slot_t            val_rd_addr_r, val_rd_addr_nxt;
  logic [VAL_W-1:0] val_rd_data;
  logic             resp_valid;
  logic             resp_ready;
  out_word_t        resp_word;
  logic             out_valid_r, out_valid_nxt;
  out_word_t        out_word_r, out_word_nxt;

  alle_ctrl u_ctrl (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_word      (in_word),
    .link_wr      (link_wr),
    .link_rd_addr (link_rd_addr),
    .link_rd_data (link_rd_data),
    .val_wr       (val_wr),
    .resp_valid   (resp_valid),
    .resp_word    (resp_word),
    .resp_ready   (resp_ready)
  );

  alle_ram #(
    .WIDTH (SLOT_W),
    .DEPTH (SLOTS)
  ) u_link_ram (
    .clk     (clk),
    .wr_en   (link_wr.en),
    .wr_addr (link_wr.addr),
    .wr_data (link_wr.data),
    .rd_addr (link_rd_addr),
    .rd_data (link_rd_data)
  );

  alle_ram #(
    .WIDTH (VAL_W),
    .DEPTH (SLOTS)
  ) u_value_ram (
    .clk     (clk),
    .wr_en   (val_wr.en),
    .wr_addr (val_wr.addr),
    .wr_data (val_wr.data),
    .rd_addr (val_rd_addr_r),
    .rd_data (val_rd_data)
  );

  assign val_rd_addr_nxt = val_wr.en ? val_wr.addr : val_rd_addr_r;

  always_ff @(posedge clk) begin
    val_rd_addr_r <= val_rd_addr_nxt;
  end

  assign resp_ready = !out_valid_r || !out_stall;

  always_comb begin
    out_valid_nxt = out_valid_r;
    out_word_nxt  = out_word_r;
    if (resp_valid && resp_ready) begin
      out_valid_nxt = 1'b1;
      out_word_nxt  = resp_word;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_word_r <= out_word_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;

  `ALLE_ASSERT_NEXT(a_accept_busy, clk, rst_n, in_valid && !in_stall, in_stall)
  `ALLE_ASSERT_SAME(a_full_len, clk, rst_n, out_valid && out_word.status == ST_FULL,
                    out_word.length == LEN_W'(SLOTS))
  `ALLE_ASSERT_SAME(a_empty_len, clk, rst_n, out_valid && out_word.status == ST_EMPTY,
                    out_word.length == '0)
  `ALLE_ASSERT_SAME(a_value_store, clk, rst_n, $past(val_wr.en, 2),
                    val_rd_data == $past(val_wr.data, 2))

endmodule
